@@ hw/rtl/tpco_pkg.sv @@
// Shared types, widths and helper functions for the three-point angle sorter.
package tpco_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int NUM_FIELDS  = 6;
    localparam int PAYLOAD_W   = NUM_FIELDS * COORD_WIDTH;
    localparam int TDATA_W     = ((PAYLOAD_W + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [COORD_WIDTH-1:0]        t_mag;
    typedef logic [PROD_WIDTH-1:0]         t_prod;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    typedef enum logic [2:0] {
        Q_ORIGIN = 3'd0,
        Q_ONE    = 3'd1,
        Q_TWO    = 3'd2,
        Q_THREE  = 3'd3,
        Q_FOUR   = 3'd4
    } t_quad;

    function automatic t_quad quad_of(input t_pt p);
        t_quad q;
        q = Q_ORIGIN;
        if (p.x > 0 && p.y >= 0) begin
            q = Q_ONE;
        end else if (p.x <= 0 && p.y > 0) begin
            q = Q_TWO;
        end else if (p.x < 0 && p.y <= 0) begin
            q = Q_THREE;
        end else if (p.x >= 0 && p.y < 0) begin
            q = Q_FOUR;
        end
        return q;
    endfunction

    // |v| fits in COORD_WIDTH unsigned bits, including the most negative value
    function automatic t_mag mag_of(input t_coord v);
        t_coord neg;
        neg = -v;
        return v[COORD_WIDTH-1] ? t_mag'(neg) : t_mag'(v);
    endfunction

endpackage

@@ hw/rtl/three_point_ccw_order.sv @@
// Top level: sorts a triple of 2D points counter-clockwise by polar angle.
// A user's view: one point triple is taken per beat and the sorted triple comes out
// after passing through three compare-exchange steps, pairs (1,2), (1,3), (2,3), each
// two register stages deep (cross products, then the exchange); a new triple can be
// accepted every cycle unless backpressure stalls the pipeline. Points on the origin
// sort first; within a quadrant points order by slope without division. Backpressure
// stalls each stage only when it holds data, so bubbles are squeezed out.
module three_point_ccw_order (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y
    input  logic [tpco_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // sorted_first_x, sorted_first_y, sorted_second_x, sorted_second_y,
    // sorted_third_x, sorted_third_y
    output logic [tpco_pkg::TDATA_W-1:0] m_axis_tdata
);
    import tpco_pkg::*;

    t_pt  p0_0, p0_1, p0_2;
    t_pt  p1_0, p1_1, p1_2;
    t_pt  p2_0, p2_1, p2_2;
    t_pt  p3_0, p3_1, p3_2;
    logic v1, v2, rd1, rd2;

    assign p0_0.x = t_coord'(s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
    assign p0_0.y = t_coord'(s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
    assign p0_1.x = t_coord'(s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
    assign p0_1.y = t_coord'(s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH]);
    assign p0_2.x = t_coord'(s_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH]);
    assign p0_2.y = t_coord'(s_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH]);

    // pair (1,2)
    tpco_cex u_cex_12 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_a     (p0_0),
        .i_b     (p0_1),
        .i_c     (p0_2),
        .o_valid (v1),
        .i_ready (rd1),
        .o_a     (p1_0),
        .o_b     (p1_1),
        .o_c     (p1_2)
    );

    // pair (1,3)
    tpco_cex u_cex_13 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .o_ready (rd1),
        .i_a     (p1_0),
        .i_b     (p1_2),
        .i_c     (p1_1),
        .o_valid (v2),
        .i_ready (rd2),
        .o_a     (p2_0),
        .o_b     (p2_2),
        .o_c     (p2_1)
    );

    // pair (2,3)
    tpco_cex u_cex_23 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .o_ready (rd2),
        .i_a     (p2_1),
        .i_b     (p2_2),
        .i_c     (p2_0),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_a     (p3_1),
        .o_b     (p3_2),
        .o_c     (p3_0)
    );

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[PAYLOAD_W-1:0] = {p3_2.y, p3_2.x, p3_1.y, p3_1.x, p3_0.y, p3_0.x};
    end

endmodule

@@ hw/rtl/tpco_cex.sv @@
// One compare-exchange step: stage one forms quadrants, magnitudes and cross products,
// stage two decides the exchange and registers the reordered points.
module tpco_cex (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  tpco_pkg::t_pt i_a,
    input  tpco_pkg::t_pt i_b,
    input  tpco_pkg::t_pt i_c,
    output logic         o_valid,
    input  logic         i_ready,
    output tpco_pkg::t_pt o_a,
    output tpco_pkg::t_pt o_b,
    output tpco_pkg::t_pt o_c
);
    import tpco_pkg::*;

    logic  r_va, r_vb;
    logic  rdy_a, rdy_b;
    t_pt   r_a1, r_b1, r_c1;
    t_quad r_qa, r_qb;
    t_mag  r_ax1, r_ay1, r_ax2, r_ay2;
    t_prod r_l, r_r;
    t_pt   r_a2, r_b2, r_c2;
    t_mag  ax1, ay1, ax2, ay2;
    logic  swap;

    assign rdy_b   = !r_vb || i_ready;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vb;
    assign o_a     = r_a2;
    assign o_b     = r_b2;
    assign o_c     = r_c2;

    assign ax1 = mag_of(i_a.x);
    assign ay1 = mag_of(i_a.y);
    assign ax2 = mag_of(i_b.x);
    assign ay2 = mag_of(i_b.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_a1  <= i_a;
            r_b1  <= i_b;
            r_c1  <= i_c;
            r_qa  <= quad_of(i_a);
            r_qb  <= quad_of(i_b);
            r_ax1 <= ax1;
            r_ay1 <= ay1;
            r_ax2 <= ax2;
            r_ay2 <= ay2;
            r_l   <= ay1 * ax2;
            r_r   <= ay2 * ax1;
        end
    end

    // slope compare by cross products; a full tie swaps unless both x are zero
    always_comb begin
        swap = 1'b0;
        if (r_qa < r_qb) begin
            swap = 1'b0;
        end else if (r_qb < r_qa) begin
            swap = 1'b1;
        end else if (r_ax1 == '0 && r_ax2 == '0) begin
            swap = r_ay1 > r_ay2;
        end else if (r_qa == Q_ONE || r_qa == Q_THREE) begin
            if (r_l != r_r) begin
                swap = r_l > r_r;
            end else begin
                swap = r_ax1 >= r_ax2;
            end
        end else if (r_ax1 == '0) begin
            swap = 1'b0;
        end else if (r_ax2 == '0) begin
            swap = 1'b1;
        end else if (r_l != r_r) begin
            swap = r_l < r_r;
        end else begin
            swap = r_ay1 >= r_ay2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_va) begin
            r_a2 <= swap ? r_b1 : r_a1;
            r_b2 <= swap ? r_a1 : r_b1;
            r_c2 <= r_c1;
        end
    end

endmodule

@@ sim/three_point_ccw_order_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the three-point counter-clockwise sorter.
module three_point_ccw_order_test;
    import tpco_pkg::*;

    localparam int CW          = COORD_WIDTH;
    localparam int RANDOM_BEATS = 600;
    localparam int DIR_ROWS    = 23;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AFTER  = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_REPORTS = 10;

    localparam int PAIR_LO [3] = '{0, 0, 1};
    localparam int PAIR_HI [3] = '{1, 2, 2};
    localparam int STALL_PCT [4] = '{0, 25, 50, 90};
    localparam int EXTREMES [5] = '{-32768, -1, 0, 1, 32767};

    // field 0 in the low bits: x1, y1, x2, y2, x3, y3
    typedef logic [5:0][CW-1:0] t_field_set;

    // x1, y1, x2, y2, x3, y3, known, then the sorted six when known
    int plan [DIR_ROWS][13] = '{
        '{0, 0, 0, 0, 0, 0,                 1, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 1, -1, 0,                1, 1, 0, 0, 1, -1, 0},
        '{0, -1, -1, 0, 0, 1,               1, 0, 1, -1, 0, 0, -1},
        '{5, 5, 0, 0, -3, 2,                1, 0, 0, 5, 5, -3, 2},
        '{32767, 32767, -32768, -32768, -32768, 32767,
          1, 32767, 32767, -32768, 32767, -32768, -32768},
        '{32767, -32768, 0, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 5, 0, 3, 0, 7,                 0, 0, 0, 0, 0, 0, 0},
        '{2, 2, 1, 1, 3, 3,                 0, 0, 0, 0, 0, 0, 0},
        '{4, 4, 4, 4, 1, 2,                 0, 0, 0, 0, 0, 0, 0},
        '{-3, 4, 0, 9, -1, 1,               0, 0, 0, 0, 0, 0, 0},
        '{-2, 2, -1, 1, -5, 5,              0, 0, 0, 0, 0, 0, 0},
        '{3, -3, 0, -2, 1, -1,              0, 0, 0, 0, 0, 0, 0},
        '{-4, -2, -2, -1, -6, -3,           0, 0, 0, 0, 0, 0, 0},
        '{-3, 3, -3, 3, -3, 3,              0, 0, 0, 0, 0, 0, 0},
        '{32767, 1, 1, 32767, -32768, -1,   0, 0, 0, 0, 0, 0, 0},
        '{-32768, -32768, -1, -1, -32768, -32768, 0, 0, 0, 0, 0, 0, 0},
        '{-1, -1, -1, -1, -1, -1,           0, 0, 0, 0, 0, 0, 0},
        '{0, -32768, 0, 32767, 32767, 0,    0, 0, 0, 0, 0, 0, 0},
        '{0, -1, 0, -32768, 5, -5,          0, 0, 0, 0, 0, 0, 0},
        '{-5, 0, 5, 0, 0, 0,                0, 0, 0, 0, 0, 0, 0},
        '{32767, 0, 7, 0, 0, 0,             0, 0, 0, 0, 0, 0, 0},
        '{-32768, 0, -1, 0, -32768, -32767, 0, 0, 0, 0, 0, 0, 0},
        '{0, -32768, 32767, -32768, 1, -32768, 0, 0, 0, 0, 0, 0, 0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // first_x, first_y, second_x, second_y, third_x, third_y
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // sorted_first_x, sorted_first_y, sorted_second_x, sorted_second_y,
    // sorted_third_x, sorted_third_y
    logic [TDATA_W-1:0]  m_axis_tdata;

    // expectation travelling alongside the offered beat
    logic                offered_known = 1'b0;
    t_field_set          offered_sorted = '0;

    t_field_set          expected_orders [$];
    int                  triples_taken = 0;
    int                  orders_seen = 0;
    int                  mismatches = 0;
    int                  cycles = 0;

    int                  hold_left = 0;
    bit                  hold_done = 1'b0;
    int                  phase_left = 0;
    int                  stall_pct = 0;

    three_point_ccw_order u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_quad quadrant(input t_pt p);
        if (p.x > 0 && p.y >= 0) return Q_ONE;
        if (p.x <= 0 && p.y > 0) return Q_TWO;
        if (p.x < 0 && p.y <= 0) return Q_THREE;
        if (p.x >= 0 && p.y < 0) return Q_FOUR;
        return Q_ORIGIN;
    endfunction

    function automatic t_mag magnitude(input t_coord v);
        t_mag m;
        m = v;
        if (v < 0) begin
            m = ~m + 1'b1;
        end
        return m;
    endfunction

    // true when a belongs after b
    function automatic bit needs_exchange(input t_pt a, input t_pt b);
        t_quad qa;
        t_quad qb;
        t_mag  ax, ay, bx, by;
        t_prod lhs, rhs;
        qa = quadrant(a);
        qb = quadrant(b);
        if (qa != qb) return qa > qb;
        ax = magnitude(a.x);
        ay = magnitude(a.y);
        bx = magnitude(b.x);
        by = magnitude(b.y);
        if (ax == 0 && bx == 0) return ay > by;
        lhs = t_prod'(ay) * t_prod'(bx);
        rhs = t_prod'(by) * t_prod'(ax);
        if (qa == Q_ONE || qa == Q_THREE) begin
            if (lhs != rhs) return lhs > rhs;
            return ax >= bx;
        end
        // quadrants two and four: y axis first, then steeper first
        if (ax == 0) return 1'b0;
        if (bx == 0) return 1'b1;
        if (lhs != rhs) return lhs < rhs;
        return ay >= by;
    endfunction

    function automatic t_field_set ccw_sort(input t_field_set raw);
        t_pt        pts [3];
        t_pt        spare;
        t_field_set ordered;
        for (int i = 0; i < 3; i++) begin
            pts[i].x = raw[2*i];
            pts[i].y = raw[2*i+1];
        end
        for (int s = 0; s < 3; s++) begin
            if (needs_exchange(pts[PAIR_LO[s]], pts[PAIR_HI[s]])) begin
                spare = pts[PAIR_LO[s]];
                pts[PAIR_LO[s]] = pts[PAIR_HI[s]];
                pts[PAIR_HI[s]] = spare;
            end
        end
        for (int i = 0; i < 3; i++) begin
            ordered[2*i]   = pts[i].x;
            ordered[2*i+1] = pts[i].y;
        end
        return ordered;
    endfunction

    function automatic string show(input t_field_set v);
        return $sformatf("(%0d,%0d) (%0d,%0d) (%0d,%0d)",
                         $signed(v[0]), $signed(v[1]), $signed(v[2]),
                         $signed(v[3]), $signed(v[4]), $signed(v[5]));
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d orders pending",
                     cycles, expected_orders.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // input beats are queued before output beats are checked
    always @(posedge i_clk) begin : scoreboard
        t_field_set got;
        t_field_set want;
        logic [5:0] diff;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (offered_known) begin
                    expected_orders.push_back(offered_sorted);
                end else begin
                    expected_orders.push_back(ccw_sort(s_axis_tdata[PAYLOAD_W-1:0]));
                end
                triples_taken <= triples_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[PAYLOAD_W-1:0];
                if (expected_orders.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected beat %0d: %s", orders_seen, show(got));
                    end
                end else begin
                    want = expected_orders.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        diff[f] = (got[f] !== want[f]);
                    end
                    if (diff != 0) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("beat %0d fields %06b differ: expected %s, got %s",
                                     orders_seen, diff, show(want), show(got));
                        end
                    end
                end
                orders_seen <= orders_seen + 1;
            end
        end
    end

    // receiver: random stall phases, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && triples_taken >= HOLD_AFTER) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                phase_left <= $urandom_range(1, 64);
                stall_pct <= STALL_PCT[$urandom_range(0, 3)];
            end else begin
                phase_left <= phase_left - 1;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin : sender
        t_field_set v;
        t_field_set known;
        bit         is_known;
        int         sent;
        int         total;
        int         burst;
        int         gap;
        int         mode;
        int         sx, sy, bx, by, k, px, py;
        total = DIR_ROWS + RANDOM_BEATS;
        sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (sent < total) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 20);
            while (burst > 0 && sent < total) begin
                is_known = 1'b0;
                known = '0;
                if (sent < DIR_ROWS) begin
                    for (int f = 0; f < 6; f++) begin
                        v[f] = t_coord'(plan[sent][f]);
                        known[f] = t_coord'(plan[sent][7+f]);
                    end
                    is_known = (plan[sent][6] != 0);
                end else begin
                    mode = $urandom_range(0, 9);
                    sx = $urandom_range(0, 1) ? 1 : -1;
                    sy = $urandom_range(0, 1) ? 1 : -1;
                    bx = $urandom_range(0, 12);
                    by = $urandom_range(0, 12);
                    for (int i = 0; i < 3; i++) begin
                        case (mode)
                            0, 1, 2: begin
                                v[2*i]   = t_coord'($urandom);
                                v[2*i+1] = t_coord'($urandom);
                            end
                            3, 4: begin
                                v[2*i]   = t_coord'($urandom_range(0, 6) - 3);
                                v[2*i+1] = t_coord'($urandom_range(0, 6) - 3);
                            end
                            5, 6, 7: begin
                                // common slope, so ties and exact cross products
                                k = $urandom_range(0, 2500);
                                px = sx * bx * k;
                                py = sy * by * k;
                                if ($urandom_range(0, 7) == 0) begin
                                    px = -px;
                                end
                                v[2*i]   = t_coord'(px);
                                v[2*i+1] = t_coord'(py);
                            end
                            8: begin
                                if ($urandom_range(0, 1)) begin
                                    v[2*i]   = '0;
                                    v[2*i+1] = t_coord'($urandom);
                                end else begin
                                    v[2*i]   = t_coord'($urandom);
                                    v[2*i+1] = '0;
                                end
                            end
                            default: begin
                                v[2*i]   = t_coord'(EXTREMES[$urandom_range(0, 4)]);
                                v[2*i+1] = t_coord'(EXTREMES[$urandom_range(0, 4)]);
                            end
                        endcase
                    end
                    if ($urandom_range(0, 5) == 0) begin
                        v[4] = v[0];
                        v[5] = v[1];
                    end
                end
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= TDATA_W'(v);
                offered_known <= is_known;
                offered_sorted <= known;
                do @(posedge i_clk); while (!s_axis_tready);
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        while (orders_seen < total) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
